// File: rtl/hlrr_pkg.sv
// Shared types, widths and constants of the hit-to-line residual block.
package hlrr_pkg;

  localparam int unsigned COORD_WIDTH    = 24;
  localparam int unsigned DIR_WIDTH      = 18;
  localparam int unsigned NORM_WIDTH     = 18;
  localparam int unsigned CFG_DATA_WIDTH = (COORD_WIDTH > DIR_WIDTH) ? COORD_WIDTH : DIR_WIDTH;
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned REGION_WIDTH   = 5;

  // Fixed-point chain: shift amounts of the three rounding steps
  localparam int unsigned D16_SHIFT = 12;
  localparam int unsigned LAM_SHIFT = 16;
  localparam int unsigned OFF_SHIFT = 20;

  // Datapath widths, each sized to hold its full range
  localparam int unsigned DIFF_W  = COORD_WIDTH + 1;
  localparam int unsigned PROD_W  = DIFF_W + DIR_WIDTH;
  localparam int unsigned DOT_W   = PROD_W + 2;
  localparam int unsigned D16_W   = DOT_W - D16_SHIFT;
  localparam int unsigned LPROD_W = D16_W + NORM_WIDTH + 1;
  localparam int unsigned LAM_W   = LPROD_W - LAM_SHIFT;
  localparam int unsigned OPROD_W = LAM_W + DIR_WIDTH;
  localparam int unsigned OFF_W   = OPROD_W - OFF_SHIFT;
  localparam int unsigned PROJ_W  = ((OFF_W > COORD_WIDTH) ? OFF_W : COORD_WIDTH) + 1;
  localparam int unsigned RES_W   = PROJ_W + 1;

  // Grid: bin edges in coordinate units, Q11.12 fraction bits
  localparam int unsigned GRID_FRAC = 12;
  localparam int unsigned GRID_TOP  = 32;
  localparam int unsigned GRID_BITS = $clog2(GRID_TOP);
  localparam int unsigned GRID_DIM  = 5;
  localparam int unsigned NUM_EDGES = GRID_DIM - 1;
  localparam int unsigned BIN_EDGE [NUM_EDGES] = '{5, 12, 20, 27};
  localparam int unsigned BIN_W     = $clog2(GRID_DIM);

  localparam int unsigned NUM_STAGES = 8;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Y = 3'd1,
    REG_CENTRE_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_INV_NORM = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] centre_x;
    logic signed [COORD_WIDTH-1:0] centre_y;
    logic signed [COORD_WIDTH-1:0] centre_z;
    logic signed [DIR_WIDTH-1:0]   dir_x;
    logic signed [DIR_WIDTH-1:0]   dir_y;
    logic signed [DIR_WIDTH-1:0]   dir_z;
    logic [NORM_WIDTH-1:0]         inv_norm;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] hit_px;
    logic signed [COORD_WIDTH-1:0] hit_py;
    logic signed [COORD_WIDTH-1:0] hit_pz;
  } hit_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] resid_x;
    logic signed [COORD_WIDTH-1:0] resid_y;
    logic signed [COORD_WIDTH-1:0] resid_z;
    logic [REGION_WIDTH-1:0]       region_index;
    logic                          in_grid;
    logic                          saturated;
  } result_t;

endpackage

// File: rtl/hlrr_cfg.sv
// Configuration register bank: line centre, direction and reciprocal norm.
module hlrr_cfg
  import hlrr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTRE_X: cfg_d.centre_x = cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CENTRE_Y: cfg_d.centre_y = cfg_wdata_i[COORD_WIDTH-1:0];
        REG_CENTRE_Z: cfg_d.centre_z = cfg_wdata_i[COORD_WIDTH-1:0];
        REG_DIR_X:    cfg_d.dir_x    = cfg_wdata_i[DIR_WIDTH-1:0];
        REG_DIR_Y:    cfg_d.dir_y    = cfg_wdata_i[DIR_WIDTH-1:0];
        REG_DIR_Z:    cfg_d.dir_z    = cfg_wdata_i[DIR_WIDTH-1:0];
        REG_INV_NORM: cfg_d.inv_norm = cfg_wdata_i[NORM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centre_x <= '0;
      cfg_q.centre_y <= '0;
      cfg_q.centre_z <= '0;
      cfg_q.dir_x    <= DIR_WIDTH'(65536);
      cfg_q.dir_y    <= '0;
      cfg_q.dir_z    <= '0;
      cfg_q.inv_norm <= NORM_WIDTH'(65536);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/hit_line_residual_region_core.sv
// Projects each 3D hit onto the configured track line and returns the residual
// vector (projection minus hit, saturated) and the 5x5 grid cell of the projected
// x,y point. The datapath is an eight-stage pipeline: difference, dot-product
// multiplies, sum and round, scale by the reciprocal norm, round, offset
// multiplies, round and add centre, then residual, clipping and binning. One hit
// is taken every cycle while the output does not stall. Each stage holds its
// request under output stall and bubbles close up, so new hits are still taken
// until the pipeline is full. The user must write configuration through the
// plain write port only while the pipeline is empty; the block does not check it.
module hit_line_residual_region_core
  import hlrr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  hit_t                      in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output result_t                   out_rsp_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  localparam logic signed [DOT_W-1:0]   RndDot = DOT_W'(1) << (D16_SHIFT - 1);
  localparam logic signed [LPROD_W-1:0] RndLam = LPROD_W'(1) << (LAM_SHIFT - 1);
  localparam logic signed [OPROD_W-1:0] RndOff = OPROD_W'(1) << (OFF_SHIFT - 1);
  localparam int unsigned GridW = GRID_FRAC + GRID_BITS;

  function automatic logic [COORD_WIDTH:0] sat_coord(logic signed [RES_W-1:0] v);
    logic over;
    over = (v[RES_W-1:COORD_WIDTH-1] != {(RES_W-COORD_WIDTH+1){v[RES_W-1]}});
    if (over) begin
      return {1'b1, v[RES_W-1], {(COORD_WIDTH-1){~v[RES_W-1]}}};
    end
    return {1'b0, v[COORD_WIDTH-1:0]};
  endfunction

  function automatic logic [BIN_W-1:0] bin_of(logic [GridW-1:0] v);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      if (v >= GridW'(BIN_EDGE[i] << GRID_FRAC)) begin
        b = b + BIN_W'(1);
      end
    end
    return b;
  endfunction

  cfg_t cfg;

  hlrr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Stage control: a stage loads when empty or when its content moves on
  logic [NUM_STAGES-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) vld_d[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  // Hit carried alongside the first seven stages for the final subtraction
  hit_t hit_q [NUM_STAGES-1];

  // Stage datapath
  logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic signed [PROD_W-1:0]  mx_q, my_q, mz_q, mx_d, my_d, mz_d;
  logic signed [DOT_W-1:0]   dot_sum;
  logic signed [D16_W-1:0]   d16_q, d16_d;
  logic signed [NORM_WIDTH:0] norm_s;
  logic signed [LPROD_W-1:0] lp_q, lp_d;
  logic signed [LAM_W-1:0]   lam_q, lam_d;
  logic signed [OPROD_W-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic signed [PROJ_W-1:0]  prx_q, pry_q, prz_q, prx_d, pry_d, prz_d;
  logic signed [RES_W-1:0]   res_x, res_y, res_z;
  logic [COORD_WIDTH:0]      sat_x, sat_y, sat_z;
  logic                      on_grid;
  logic [BIN_W-1:0]          bin_x, bin_y;
  result_t                   rsp_q, rsp_d;

  always_comb begin
    dx_d = DIFF_W'(in_req_i.hit_px) - DIFF_W'(cfg.centre_x);
    dy_d = DIFF_W'(in_req_i.hit_py) - DIFF_W'(cfg.centre_y);
    dz_d = DIFF_W'(in_req_i.hit_pz) - DIFF_W'(cfg.centre_z);

    mx_d = dx_q * $signed(cfg.dir_x);
    my_d = dy_q * $signed(cfg.dir_y);
    mz_d = dz_q * $signed(cfg.dir_z);

    dot_sum = DOT_W'(mx_q) + DOT_W'(my_q) + DOT_W'(mz_q) + RndDot;
    d16_d   = D16_W'(dot_sum >>> D16_SHIFT);

    norm_s = $signed({1'b0, cfg.inv_norm});
    lp_d   = d16_q * norm_s;

    lam_d = LAM_W'((lp_q + RndLam) >>> LAM_SHIFT);

    ox_d = lam_q * $signed(cfg.dir_x);
    oy_d = lam_q * $signed(cfg.dir_y);
    oz_d = lam_q * $signed(cfg.dir_z);

    prx_d = PROJ_W'($signed(cfg.centre_x)) + PROJ_W'((ox_q + RndOff) >>> OFF_SHIFT);
    pry_d = PROJ_W'($signed(cfg.centre_y)) + PROJ_W'((oy_q + RndOff) >>> OFF_SHIFT);
    prz_d = PROJ_W'($signed(cfg.centre_z)) + PROJ_W'((oz_q + RndOff) >>> OFF_SHIFT);

    res_x = RES_W'(prx_q) - RES_W'($signed(hit_q[NUM_STAGES-2].hit_px));
    res_y = RES_W'(pry_q) - RES_W'($signed(hit_q[NUM_STAGES-2].hit_py));
    res_z = RES_W'(prz_q) - RES_W'($signed(hit_q[NUM_STAGES-2].hit_pz));
    sat_x = sat_coord(res_x);
    sat_y = sat_coord(res_y);
    sat_z = sat_coord(res_z);

    // Grid top is a power of two: on the grid means no bits above it and not negative
    on_grid = (prx_q[PROJ_W-1:GridW] == '0) && (pry_q[PROJ_W-1:GridW] == '0);
    bin_x   = bin_of(prx_q[GridW-1:0]);
    bin_y   = bin_of(pry_q[GridW-1:0]);

    rsp_d.resid_x      = sat_x[COORD_WIDTH-1:0];
    rsp_d.resid_y      = sat_y[COORD_WIDTH-1:0];
    rsp_d.resid_z      = sat_z[COORD_WIDTH-1:0];
    rsp_d.saturated    = sat_x[COORD_WIDTH] | sat_y[COORD_WIDTH] | sat_z[COORD_WIDTH];
    rsp_d.in_grid      = on_grid;
    rsp_d.region_index = on_grid ?
        REGION_WIDTH'(bin_x) * REGION_WIDTH'(GRID_DIM) + REGION_WIDTH'(bin_y) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      dz_q     <= dz_d;
      hit_q[0] <= in_req_i;
    end
    if (rdy[1]) begin
      mx_q <= mx_d;
      my_q <= my_d;
      mz_q <= mz_d;
    end
    if (rdy[2]) d16_q <= d16_d;
    if (rdy[3]) lp_q  <= lp_d;
    if (rdy[4]) lam_q <= lam_d;
    if (rdy[5]) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      oz_q <= oz_d;
    end
    if (rdy[6]) begin
      prx_q <= prx_d;
      pry_q <= pry_d;
      prz_q <= prz_d;
    end
    if (rdy[7]) rsp_q <= rsp_d;
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (rdy[k]) hit_q[k] <= hit_q[k-1];
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

// File: rtl/hlrr_checker.sv
// Port-level checks of the hit-to-line residual block, bound to the top level.
module hlrr_checker
  import hlrr_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input result_t out_rsp_o
);

  // A result held under stall stays presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Without output stall every stage can advance, so requests are never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with free output");

  // Outside the grid the region reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.in_grid |-> out_rsp_o.region_index == '0)
    else $error("region set outside grid");

  // A request flows through all eight stages when the output never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind hit_line_residual_region_core hlrr_checker u_hlrr_checker (.*);
